@@ hdl/ier_pkg.sv @@
package ier_pkg;

  localparam int unsigned FRAME_DEPTH = 2048;
  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned CW = $clog2(FRAME_DEPTH + 2);
  localparam int unsigned IW = (CW > 8) ? CW : 8;

  localparam int unsigned HDR_BYTES = 34;
  localparam int unsigned L4_HDR_BYTES = 6;
  localparam int unsigned ETH_HDR_LEN = 14;
  localparam int unsigned REPLY_L4_START = 34;
  localparam int unsigned TIME_REPLY_LEN = 46;
  localparam int unsigned MIN_L4_LEN = 8;

  localparam logic [31:0] TIME_OFFSET = 32'd2208988800;
  localparam logic [7:0] IP_VER_IHL = 8'h45;
  localparam logic [7:0] IP_TTL = 8'd64;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [15:0] PORT_TIME = 16'd37;
  localparam logic [15:0] PORT_ECHO = 16'd7;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0] UDP_TIME_LEN = 8'd12;

  typedef enum logic [2:0] {
    VD_NONE,
    VD_ICMP,
    VD_TIME,
    VD_ECHO,
    VD_MALFORMED,
    VD_BUSY
  } verdict_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PUSH_LAST,
    OP_PULL
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  data;
    logic [15:0] ident;
    logic [31:0] secs;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } cmd_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_L4RD,
    S_DECIDE,
    S_HSUM,
    S_HFOLD,
    S_PSUM,
    S_EMIT,
    S_PULL_RD,
    S_PULL_OUT
  } state_e;

endpackage

@@ hdl/ier_front.sv @@
module ier_front import ier_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [55:0] in_data_i,
  input  logic        in_last_i,
  input  logic        in_user_i,
  input  logic        cmd_pop_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o
);

  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    cmd_new.data  = in_data_i[7:0];
    cmd_new.ident = in_data_i[23:8];
    cmd_new.secs  = in_data_i[55:24];
    if (in_user_i) begin
      cmd_new.op = OP_PULL;
    end else if (in_last_i) begin
      cmd_new.op = OP_PUSH_LAST;
    end else begin
      cmd_new.op = OP_PUSH;
    end
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ hdl/ier_back.sv @@
module ier_back import ier_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] local_ipv4_i,
  input  cmd_ctrl_t   ctrl_i,
  output logic        cmd_pop_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output verdict_e    res_verdict_o,
  output logic        res_reply_valid_o,
  output logic [7:0]  res_byte_o,
  output logic        res_last_o
);

  logic [7:0] mem_q [FRAME_DEPTH];
  logic [7:0] rdata_q;
  logic [AW-1:0] raddr;
  logic mem_we;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, n_q, n_d;
  logic pending_q, pending_d;
  verdict_e kind_q, kind_d, emit_vd_q, emit_vd_d;
  logic [IW-1:0] rlen_q, rlen_d, ridx_q, ridx_d, rc_q, rc_d, avail_q, avail_d;
  logic [IW-1:0] base_q, base_d;
  logic [15:0] hcs_q, hcs_d, pcs_q, pcs_d, ident_q, ident_d, eth_q, eth_d, acc_q, acc_d;
  logic [31:0] time_q, time_d;
  logic [19:0] hsum_q, hsum_d;
  logic rv_q, rv_d, rpar_q, rpar_d;
  logic [7:0] hdr_q [HDR_BYTES];
  logic [7:0] l4h_q [L4_HDR_BYTES];
  logic hdr_shift, l4_shift;
  logic [7:0] hb [HDR_BYTES];
  logic [7:0] lb [L4_HDR_BYTES];

  logic ov_q, ov_d, orv_q, orv_d, ol_q, ol_d;
  verdict_e ovd_q, ovd_d;
  logic [7:0] ob_q, ob_d;
  logic out_free;

  for (genvar g = 0; g < HDR_BYTES; g++) begin : g_hb
    assign hb[g] = hdr_q[HDR_BYTES-1-g];
  end
  for (genvar g = 0; g < L4_HDR_BYTES; g++) begin : g_lb
    assign lb[g] = l4h_q[L4_HDR_BYTES-1-g];
  end

  logic [16:0] n17, total17, tot_end;
  logic [5:0]  hlen;
  logic [15:0] total, avail16, port, ulen, tl;
  logic [7:0]  proto_r;
  logic [31:0] dst, tval;
  logic [16:0] f1;
  logic [15:0] f2;
  logic [16:0] acc_sum;
  logic [7:0]  pbyte;
  logic [IW-1:0] pj, pk, paddr;
  logic [IW:0] fin_sum;
  logic fin;

  assign n17     = 17'(n_q);
  assign hlen    = {hb[14][3:0], 2'b00};
  assign total   = {hb[16], hb[17]};
  assign total17 = {1'b0, total};
  assign tot_end = 17'(ETH_HDR_LEN) + total17;
  assign avail16 = total - 16'(hlen);
  assign dst     = {hb[30], hb[31], hb[32], hb[33]};
  assign port    = {lb[2], lb[3]};
  assign ulen    = {lb[4], lb[5]};
  assign tl      = 16'(rlen_q) - 16'(ETH_HDR_LEN);
  assign proto_r = (kind_q == VD_ICMP) ? PROTO_ICMP : PROTO_UDP;
  assign tval    = time_q + TIME_OFFSET;
  assign f1      = {1'b0, hsum_q[15:0]} + {13'd0, hsum_q[19:16]};
  assign f2      = f1[15:0] + {15'd0, f1[16]};
  assign pj      = ridx_q - IW'(ETH_HDR_LEN);
  assign pk      = ridx_q - IW'(REPLY_L4_START);
  assign fin_sum = {1'b0, ridx_q} + (IW+1)'(1);
  assign fin     = fin_sum >= {1'b0, rlen_q};
  assign out_free = !ov_q || res_ready_i;

  always_comb begin
    if (rpar_q) begin
      acc_sum = {1'b0, acc_q} + {9'd0, rdata_q};
    end else begin
      acc_sum = {1'b0, acc_q} + {1'b0, rdata_q, 8'd0};
    end
  end

  always_comb begin
    if (ridx_q < IW'(6)) begin
      paddr = ridx_q + IW'(6);
    end else if (ridx_q < IW'(12)) begin
      paddr = ridx_q - IW'(6);
    end else if (ridx_q < IW'(ETH_HDR_LEN)) begin
      paddr = ridx_q;
    end else if (ridx_q < IW'(REPLY_L4_START)) begin
      if (pj >= IW'(12) && pj < IW'(16)) begin
        paddr = ridx_q + IW'(4);
      end else begin
        paddr = ridx_q - IW'(4);
      end
    end else begin
      paddr = base_q + pk;
    end
  end

  always_comb begin
    pbyte = 8'd0;
    if (ridx_q < IW'(ETH_HDR_LEN)) begin
      pbyte = rdata_q;
    end else if (ridx_q < IW'(REPLY_L4_START)) begin
      case (pj[4:0]) inside
        5'd0:            pbyte = IP_VER_IHL;
        5'd2:            pbyte = tl[15:8];
        5'd3:            pbyte = tl[7:0];
        5'd4:            pbyte = ident_q[15:8];
        5'd5:            pbyte = ident_q[7:0];
        5'd8:            pbyte = IP_TTL;
        5'd9:            pbyte = proto_r;
        5'd10:           pbyte = hcs_q[15:8];
        5'd11:           pbyte = hcs_q[7:0];
        [5'd12:5'd19]:   pbyte = rdata_q;
        default:         pbyte = 8'd0;
      endcase
    end else if (kind_q == VD_ICMP) begin
      if (pk < IW'(2)) begin
        pbyte = 8'd0;
      end else if (pk == IW'(2)) begin
        pbyte = pcs_q[15:8];
      end else if (pk == IW'(3)) begin
        pbyte = pcs_q[7:0];
      end else begin
        pbyte = rdata_q;
      end
    end else begin
      if (pk < IW'(2)) begin
        pbyte = pk[0] ? lb[3] : lb[2];
      end else if (pk < IW'(4)) begin
        pbyte = pk[0] ? lb[1] : lb[0];
      end else if (pk < IW'(6)) begin
        if (kind_q == VD_TIME) begin
          pbyte = pk[0] ? UDP_TIME_LEN : 8'd0;
        end else begin
          pbyte = pk[0] ? lb[5] : lb[4];
        end
      end else if (pk < IW'(MIN_L4_LEN)) begin
        pbyte = 8'd0;
      end else if (kind_q == VD_TIME) begin
        case (pk[1:0])
          2'd0:    pbyte = tval[31:24];
          2'd1:    pbyte = tval[23:16];
          2'd2:    pbyte = tval[15:8];
          default: pbyte = tval[7:0];
        endcase
      end else begin
        pbyte = rdata_q;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    pending_d = pending_q;
    kind_d    = kind_q;
    emit_vd_d = emit_vd_q;
    rlen_d    = rlen_q;
    ridx_d    = ridx_q;
    rc_d      = rc_q;
    avail_d   = avail_q;
    base_d    = base_q;
    hcs_d     = hcs_q;
    pcs_d     = pcs_q;
    ident_d   = ident_q;
    time_d    = time_q;
    eth_d     = eth_q;
    acc_d     = acc_q;
    hsum_d    = hsum_q;
    rv_d      = 1'b0;
    rpar_d    = rpar_q;
    hdr_shift = 1'b0;
    l4_shift  = 1'b0;
    mem_we    = 1'b0;
    cmd_pop_o = 1'b0;
    raddr     = paddr[AW-1:0];
    ov_d      = res_ready_i ? 1'b0 : ov_q;
    ovd_d     = ovd_q;
    orv_d     = orv_q;
    ob_d      = ob_q;
    ol_d      = ol_q;

    unique case (state_q)
      S_IDLE: begin
        if (ctrl_i.valid) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_PULL) begin
            if (pending_q) begin
              state_d = S_PULL_RD;
            end else begin
              emit_vd_d = VD_NONE;
              state_d   = S_EMIT;
            end
          end else if (pending_q) begin
            count_d = '0;
            if (cmd_i.op == OP_PUSH_LAST) begin
              emit_vd_d = VD_BUSY;
              state_d   = S_EMIT;
            end
          end else begin
            if (count_q < CW'(FRAME_DEPTH)) begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
              if (count_q < CW'(HDR_BYTES)) begin
                hdr_shift = 1'b1;
              end
              if (count_q == CW'(12)) begin
                eth_d[15:8] = cmd_i.data;
              end
              if (count_q == CW'(13)) begin
                eth_d[7:0] = cmd_i.data;
              end
            end else begin
              count_d = CW'(FRAME_DEPTH + 1);
            end
            if (cmd_i.op == OP_PUSH_LAST) begin
              n_d     = count_d;
              count_d = '0;
              ident_d = cmd_i.ident;
              time_d  = cmd_i.secs;
              state_d = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        base_d  = IW'(ETH_HDR_LEN) + IW'(hlen);
        avail_d = IW'(avail16);
        rc_d    = '0;
        state_d = S_EMIT;
        if (n17 > 17'(FRAME_DEPTH) || n17 < 17'(ETH_HDR_LEN)) begin
          emit_vd_d = VD_MALFORMED;
        end else if (eth_q != ETHERTYPE_IPV4) begin
          emit_vd_d = VD_NONE;
        end else if (n17 < 17'(HDR_BYTES)) begin
          emit_vd_d = VD_MALFORMED;
        end else if (hb[14][7:4] != 4'd4 || hb[14][3:0] < 4'd5) begin
          emit_vd_d = VD_MALFORMED;
        end else if (total17 < 17'(hlen) || tot_end > n17) begin
          emit_vd_d = VD_MALFORMED;
        end else if (hb[23] == PROTO_UDP) begin
          if (avail16 < 16'(MIN_L4_LEN)) begin
            emit_vd_d = VD_MALFORMED;
          end else begin
            kind_d  = VD_TIME;
            state_d = S_L4RD;
          end
        end else if (hb[23] == PROTO_ICMP) begin
          if (dst != local_ipv4_i) begin
            emit_vd_d = VD_NONE;
          end else if (avail16 < 16'(MIN_L4_LEN)) begin
            emit_vd_d = VD_MALFORMED;
          end else begin
            kind_d  = VD_ICMP;
            state_d = S_L4RD;
          end
        end else begin
          emit_vd_d = VD_NONE;
        end
      end
      S_L4RD: begin
        raddr = AW'(base_q + rc_q);
        if (rc_q < IW'(L4_HDR_BYTES)) begin
          rc_d = rc_q + IW'(1);
          rv_d = 1'b1;
        end
        if (rv_q) begin
          l4_shift = 1'b1;
        end
        if (rc_q == IW'(L4_HDR_BYTES) && !rv_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_HSUM;
        if (kind_q == VD_ICMP) begin
          if (lb[0] != ICMP_ECHO_REQUEST || lb[1] != 8'd0) begin
            emit_vd_d = VD_NONE;
            state_d   = S_EMIT;
          end else begin
            rlen_d = IW'(REPLY_L4_START) + avail_q;
          end
        end else if (port == PORT_TIME) begin
          kind_d = VD_TIME;
          rlen_d = IW'(TIME_REPLY_LEN);
        end else if (port == PORT_ECHO) begin
          if (ulen < 16'(MIN_L4_LEN) || ulen > 16'(avail_q)) begin
            emit_vd_d = VD_MALFORMED;
            state_d   = S_EMIT;
          end else begin
            kind_d = VD_ECHO;
            rlen_d = IW'(REPLY_L4_START) + IW'(ulen);
          end
        end else begin
          emit_vd_d = VD_NONE;
          state_d   = S_EMIT;
        end
      end
      S_HSUM: begin
        hsum_d = 20'({IP_VER_IHL, 8'd0}) + 20'(tl) + 20'(ident_q)
               + 20'({IP_TTL, proto_r}) + 20'({hb[30], hb[31]})
               + 20'({hb[32], hb[33]}) + 20'({hb[26], hb[27]})
               + 20'({hb[28], hb[29]});
        state_d = S_HFOLD;
      end
      S_HFOLD: begin
        hcs_d = ~f2;
        if (kind_q == VD_ICMP) begin
          rc_d    = IW'(4);
          acc_d   = '0;
          state_d = S_PSUM;
        end else begin
          pending_d = 1'b1;
          ridx_d    = '0;
          emit_vd_d = kind_q;
          state_d   = S_EMIT;
        end
      end
      S_PSUM: begin
        raddr = AW'(base_q + rc_q);
        if (rc_q < avail_q) begin
          rc_d   = rc_q + IW'(1);
          rv_d   = 1'b1;
          rpar_d = rc_q[0];
        end
        if (rv_q) begin
          acc_d = acc_sum[15:0] + {15'd0, acc_sum[16]};
        end
        if (rc_q >= avail_q && !rv_q) begin
          pcs_d     = ~acc_q;
          pending_d = 1'b1;
          ridx_d    = '0;
          emit_vd_d = kind_q;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ovd_d   = emit_vd_q;
          orv_d   = 1'b0;
          ob_d    = 8'd0;
          ol_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_PULL_RD: begin
        state_d = S_PULL_OUT;
      end
      S_PULL_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ovd_d   = VD_NONE;
          orv_d   = 1'b1;
          ob_d    = pbyte;
          ol_d    = fin;
          state_d = S_IDLE;
          if (fin) begin
            pending_d = 1'b0;
            ridx_d    = '0;
          end else begin
            ridx_d = ridx_q + IW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      n_q       <= '0;
      pending_q <= 1'b0;
      kind_q    <= VD_NONE;
      emit_vd_q <= VD_NONE;
      rlen_q    <= '0;
      ridx_q    <= '0;
      rc_q      <= '0;
      rv_q      <= 1'b0;
      hcs_q     <= '0;
      pcs_q     <= '0;
      ident_q   <= '0;
      time_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      n_q       <= n_d;
      pending_q <= pending_d;
      kind_q    <= kind_d;
      emit_vd_q <= emit_vd_d;
      rlen_q    <= rlen_d;
      ridx_q    <= ridx_d;
      rc_q      <= rc_d;
      rv_q      <= rv_d;
      hcs_q     <= hcs_d;
      pcs_q     <= pcs_d;
      ident_q   <= ident_d;
      time_q    <= time_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avail_q <= avail_d;
    base_q  <= base_d;
    eth_q   <= eth_d;
    acc_q   <= acc_d;
    hsum_q  <= hsum_d;
    rpar_q  <= rpar_d;
    ovd_q   <= ovd_d;
    orv_q   <= orv_d;
    ob_q    <= ob_d;
    ol_q    <= ol_d;
    if (hdr_shift) begin
      hdr_q[0] <= cmd_i.data;
      for (int i = 1; i < HDR_BYTES; i++) begin
        hdr_q[i] <= hdr_q[i-1];
      end
    end
    if (l4_shift) begin
      l4h_q[0] <= rdata_q;
      for (int i = 1; i < L4_HDR_BYTES; i++) begin
        l4h_q[i] <= l4h_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AW-1:0]] <= cmd_i.data;
    end
    rdata_q <= mem_q[raddr];
  end

  assign res_valid_o       = ov_q;
  assign res_verdict_o     = ovd_q;
  assign res_reply_valid_o = orv_q;
  assign res_byte_o        = ob_q;
  assign res_last_o        = ol_q;

endmodule

@@ hdl/icmp_udp_echo_responder.sv @@
// Answers ICMP echo requests and UDP time and echo requests held in one buffered frame.
// The slave stream carries commands: tuser low pushes the received byte in tdata,
// with tlast on the frame's final byte; tuser high pulls one byte of the reply.
// Every pull and every final byte produce one master transfer; other pushes none.
// The master tdata carries the verdict and the reply byte, tuser marks a reply byte.
// Pushed bytes are taken at one per cycle through a two-entry command queue while the back end is idle.
// A frame that reaches the transport checks is judged once its final byte leaves the queue,
// passing the check, L4 header read, decide, header sum and fold states; earlier rejects
// leave from the check state; an ICMP reply adds a payload checksum pass that reads
// the frame memory. A pull waits in a read state for the registered frame memory read.
// The result sits in an output register, so a stalled receiver only holds the
// back end once a second result is ready; the queue keeps accepting until it is full.
// While a reply is pending, pushed bytes are dropped and a final byte reports busy.
// Reset clears the control state and the local address; the frame memory is not
// cleared and needs no clearing pass.
module icmp_udp_echo_responder import ier_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // frame_byte, reply_ident, unix_seconds
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // verdict, reply_byte, zero fill
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // reply_valid
);

  logic [31:0] local_ipv4_q;
  cmd_ctrl_t   ctrl;
  cmd_t        cmd;
  logic        cmd_valid, cmd_pop;
  verdict_e    verdict;
  logic [7:0]  reply_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ipv4_q <= '0;
    end else if (cfg_we_i) begin
      local_ipv4_q <= cfg_wdata_i;
    end
  end

  ier_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_user_i   (s_axis_tuser),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  assign ctrl.valid = cmd_valid;
  assign ctrl.pop   = cmd_pop;

  ier_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .local_ipv4_i      (local_ipv4_q),
    .ctrl_i            (ctrl),
    .cmd_pop_o         (cmd_pop),
    .cmd_i             (cmd),
    .res_valid_o       (m_axis_tvalid),
    .res_ready_i       (m_axis_tready),
    .res_verdict_o     (verdict),
    .res_reply_valid_o (m_axis_tuser),
    .res_byte_o        (reply_byte),
    .res_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, reply_byte, verdict};

  a_last_is_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("reply end marked on a transfer without reply data");

  a_verdict_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != 3'd0) |-> !m_axis_tuser)
    else $error("verdict and reply byte in the same transfer");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> ctrl.valid)
    else $error("command popped from an empty queue");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import ier_pkg::*;

  typedef struct {
    verdict_e   verdict;
    logic       valid;
    logic [7:0] data;
    logic       last;
  } reply_item_t;

  typedef enum int {
    FK_ICMP,
    FK_TIME,
    FK_ECHO
  } frame_kind_e;

  typedef enum int {
    MU_NONE,
    MU_ETHERTYPE,
    MU_VERSION,
    MU_IHL_LOW,
    MU_OPTIONS,
    MU_TOTAL_LOW,
    MU_TOTAL_HIGH,
    MU_TRUNCATE,
    MU_SHORT_L4,
    MU_UDP_LEN,
    MU_OTHER_DST,
    MU_ICMP_TYPE,
    MU_PROTO,
    MU_PORT,
    MU_PAD,
    MU_COUNT
  } mutation_e;

  localparam logic OP_PUSH_BYTE = 1'b0;
  localparam logic OP_PULL_BYTE = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 3000;

  class echo_scoreboard;
    byte unsigned store[FRAME_DEPTH];
    int unsigned  count;
    bit           pending;
    verdict_e     kind;
    int unsigned  rlen;
    int unsigned  ridx;
    bit [15:0]    hsum;
    bit [15:0]    psum;
    bit [15:0]    ident;
    bit [31:0]    secs;
    bit [31:0]    local_ip;
    reply_item_t  exp_q[$];
    int unsigned  errors;

    function new();
      foreach (store[i]) store[i] = 0;
      count = 0;
      pending = 0;
      kind = VD_NONE;
      rlen = 0;
      ridx = 0;
      hsum = 0;
      psum = 0;
      ident = 0;
      secs = 0;
      local_ip = 0;
      errors = 0;
    endfunction

    function int unsigned rd8(int unsigned i);
      return (i < FRAME_DEPTH) ? store[i] : 0;
    endfunction

    function int unsigned rd16(int unsigned i);
      return (rd8(i) << 8) | rd8(i + 1);
    endfunction

    function int unsigned fold(int unsigned s);
      while (s >> 16) s = (s & 16'hFFFF) + (s >> 16);
      return s;
    endfunction

    function int unsigned ip_byte(int unsigned j);
      int unsigned tl;
      tl = rlen - ETH_HDR_LEN;
      case (j)
        0: return IP_VER_IHL;
        2: return (tl >> 8) & 255;
        3: return tl & 255;
        4: return ident[15:8];
        5: return ident[7:0];
        8: return IP_TTL;
        9: return (kind == VD_ICMP) ? PROTO_ICMP : PROTO_UDP;
        10: return hsum[15:8];
        11: return hsum[7:0];
        default: ;
      endcase
      if (j >= 12 && j < 16) return rd8(30 + j - 12);
      if (j >= 16 && j < 20) return rd8(26 + j - 16);
      return 0;
    endfunction

    function int unsigned l4_byte(int unsigned k);
      int unsigned base;
      bit [31:0]   t;
      base = 14 + (rd8(14) & 15) * 4;
      if (kind == VD_ICMP) begin
        if (k < 2) return 0;
        if (k == 2) return psum[15:8];
        if (k == 3) return psum[7:0];
        return rd8(base + k);
      end
      if (k < 2) return rd8(base + 2 + k);
      if (k < 4) return rd8(base + k - 2);
      if (k < 6) begin
        if (kind == VD_TIME) return (k == 4) ? 0 : UDP_TIME_LEN;
        return rd8(base + k);
      end
      if (k < 8) return 0;
      if (kind == VD_TIME) begin
        t = secs + TIME_OFFSET;
        return (t >> ((3 - ((k - 8) & 3)) * 8)) & 255;
      end
      return rd8(base + k);
    endfunction

    function int unsigned reply_at(int unsigned i);
      if (i < 6) return rd8(6 + i);
      if (i < 12) return rd8(i - 6);
      if (i < 14) return rd8(i);
      if (i < 34) return ip_byte(i - 14);
      return l4_byte(i - 34);
    endfunction

    function verdict_e judge(int unsigned n);
      int unsigned vi, hlen, tot, base, avail, port, ul, s, plen, lo, dst;
      if (n > FRAME_DEPTH || n < 14) return VD_MALFORMED;
      if (rd16(12) != ETHERTYPE_IPV4) return VD_NONE;
      if (n < 34) return VD_MALFORMED;
      vi = rd8(14);
      if ((vi >> 4) != 4 || (vi & 15) < 5) return VD_MALFORMED;
      hlen = (vi & 15) * 4;
      tot = rd16(16);
      if (tot < hlen || 14 + tot > n) return VD_MALFORMED;
      base = 14 + hlen;
      avail = tot - hlen;
      if (rd8(23) == PROTO_UDP) begin
        if (avail < 8) return VD_MALFORMED;
        port = rd16(base + 2);
        if (port == PORT_TIME) begin
          kind = VD_TIME;
          rlen = TIME_REPLY_LEN;
        end else if (port == PORT_ECHO) begin
          ul = rd16(base + 4);
          if (ul < 8 || ul > avail) return VD_MALFORMED;
          kind = VD_ECHO;
          rlen = 34 + ul;
        end else begin
          return VD_NONE;
        end
      end else if (rd8(23) == PROTO_ICMP) begin
        dst = (rd16(30) << 16) | rd16(32);
        if (dst != local_ip) return VD_NONE;
        if (avail < 8) return VD_MALFORMED;
        if (rd8(base) != ICMP_ECHO_REQUEST || rd8(base + 1) != 0) return VD_NONE;
        kind = VD_ICMP;
        rlen = 34 + avail;
      end else begin
        return VD_NONE;
      end
      hsum = 0;
      s = 0;
      for (int unsigned j = 0; j < 20; j += 2) s += (ip_byte(j) << 8) | ip_byte(j + 1);
      hsum = 16'(~fold(s));
      psum = 0;
      if (kind == VD_ICMP) begin
        plen = rlen - 34;
        s = 0;
        for (int unsigned j = 0; j < plen; j += 2) begin
          lo = (j + 1 < plen) ? l4_byte(j + 1) : 0;
          s = fold(s + ((l4_byte(j) << 8) | lo));
        end
        psum = 16'(~fold(s));
      end
      return kind;
    endfunction

    function void note_input(logic op, logic [7:0] b, logic last, logic [15:0] id,
                             logic [31:0] sec);
      reply_item_t r;
      verdict_e    v;
      r = '{VD_NONE, 1'b0, 8'd0, 1'b0};
      if (op == OP_PUSH_BYTE) begin
        if (pending) begin
          count = 0;
          if (!last) return;
          r.verdict = VD_BUSY;
          exp_q.push_back(r);
          return;
        end
        if (count < FRAME_DEPTH) begin
          store[count] = b;
          count++;
        end else begin
          count = FRAME_DEPTH + 1;
        end
        if (!last) return;
        ident = id;
        secs = sec;
        v = judge(count);
        count = 0;
        if (v inside {VD_ICMP, VD_TIME, VD_ECHO}) begin
          pending = 1;
          ridx = 0;
        end
        r.verdict = v;
        exp_q.push_back(r);
        return;
      end
      if (pending) begin
        r.valid = 1;
        r.data = 8'(reply_at(ridx));
        r.last = (ridx + 1 >= rlen);
        if (r.last) begin
          pending = 0;
          ridx = 0;
        end else begin
          ridx++;
        end
      end
      exp_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] data, logic last, logic user);
      reply_item_t e;
      if (exp_q.size() == 0) begin
        $error("unexpected result transfer: tdata %h", data);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      if (data[2:0] !== e.verdict) begin
        $error("verdict: expected %0d, got %0d", e.verdict, data[2:0]);
        errors++;
      end
      if (user !== e.valid) begin
        $error("reply_valid: expected %0d, got %0d", e.valid, user);
        errors++;
      end
      if (data[10:3] !== e.data) begin
        $error("reply_byte: expected %h, got %h", e.data, data[10:3]);
        errors++;
      end
      if (last !== e.last) begin
        $error("reply_last: expected %0d, got %0d", e.last, last);
        errors++;
      end
      if (data[15:11] !== 5'd0) begin
        $error("zero fill: expected 0, got %h", data[15:11]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  echo_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    accepted = 0;
  bit             no_idle = 0;

  icmp_udp_echo_responder uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  always begin
    int unsigned n;
    n = no_idle ? 0 : $urandom_range(0, 8);
    if (n > 0) begin
      m_axis_tready <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
    @(posedge clk_i);
  end

  task automatic send_item(logic op, logic [7:0] b, logic last);
    int unsigned gap;
    logic [15:0] id;
    logic [31:0] sec;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    id = 16'($urandom);
    sec = $urandom;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tlast <= last;
    s_axis_tdata <= {sec, id, (op == OP_PULL_BYTE) ? 8'($urandom) : b};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, b, last, id, sec);
    accepted++;
  endtask

  task automatic push_frame(byte unsigned f[$]);
    foreach (f[i]) send_item(OP_PUSH_BYTE, f[i], i == f.size() - 1);
  endtask

  task automatic drain_reply();
    while (sb.pending) send_item(OP_PULL_BYTE, 8'd0, 1'b0);
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_local(logic [31:0] v);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.local_ip = v;
  endtask

  task automatic build_frame(frame_kind_e fk, mutation_e mu, int unsigned plen,
                             ref byte unsigned f[$]);
    int unsigned hl, tot, l4;
    f.delete();
    repeat (12) f.push_back(8'($urandom));
    f.push_back(8'h08);
    f.push_back(8'h00);
    hl = (mu == MU_OPTIONS) ? 24 : 20;
    tot = hl + 8 + plen;
    f.push_back((mu == MU_OPTIONS) ? 8'h46 : IP_VER_IHL);
    f.push_back(8'($urandom));
    f.push_back(8'(tot >> 8));
    f.push_back(8'(tot & 255));
    repeat (5) f.push_back(8'($urandom));
    f.push_back((fk == FK_ICMP) ? PROTO_ICMP : PROTO_UDP);
    repeat (6) f.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) begin
      f.push_back((fk == FK_ICMP) ? sb.local_ip[i*8 +: 8] : 8'($urandom));
    end
    if (mu == MU_OPTIONS) repeat (4) f.push_back(8'($urandom));
    l4 = 14 + hl;
    if (fk == FK_ICMP) begin
      f.push_back(ICMP_ECHO_REQUEST);
      f.push_back(8'd0);
      repeat (6) f.push_back(8'($urandom));
    end else begin
      repeat (2) f.push_back(8'($urandom));
      f.push_back(8'd0);
      f.push_back((fk == FK_TIME) ? PORT_TIME[7:0] : PORT_ECHO[7:0]);
      f.push_back(8'((8 + plen) >> 8));
      f.push_back(8'((8 + plen) & 255));
      repeat (2) f.push_back(8'($urandom));
    end
    repeat (plen) f.push_back(8'($urandom));
    case (mu)
      MU_ETHERTYPE: f[13] = 8'($urandom_range(1, 255));
      MU_VERSION: f[14] = {4'(($urandom_range(5, 19)) & 15), 4'd5};
      MU_IHL_LOW: f[14] = {4'd4, 4'($urandom_range(0, 4))};
      MU_TOTAL_LOW: begin
        tot = $urandom_range(0, hl - 1);
        f[16] = 8'(tot >> 8);
        f[17] = 8'(tot & 255);
      end
      MU_TOTAL_HIGH: begin
        tot = f.size() - 14 + $urandom_range(1, 300);
        f[16] = 8'(tot >> 8);
        f[17] = 8'(tot & 255);
      end
      MU_TRUNCATE: while (f.size() > $urandom_range(1, 33)) void'(f.pop_back());
      MU_SHORT_L4: begin
        tot = hl + $urandom_range(0, 7);
        f[16] = 8'(tot >> 8);
        f[17] = 8'(tot & 255);
      end
      MU_UDP_LEN: begin
        tot = $urandom_range(0, 1) ? $urandom_range(0, 7) : 8 + plen + $urandom_range(1, 999);
        f[l4 + 4] = 8'(tot >> 8);
        f[l4 + 5] = 8'(tot & 255);
      end
      MU_OTHER_DST: f[33] = f[33] ^ 8'($urandom_range(1, 255));
      MU_ICMP_TYPE: begin
        if ($urandom_range(0, 1)) f[l4] = 8'($urandom_range(9, 263));
        else f[l4 + 1] = 8'($urandom_range(1, 255));
      end
      MU_PROTO: f[23] = 8'($urandom_range(18, 272));
      MU_PORT: f[l4 + 2] = 8'($urandom_range(1, 255));
      MU_PAD: repeat ($urandom_range(1, 20)) f.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic run_frame(frame_kind_e fk, mutation_e mu, int unsigned plen);
    byte unsigned f[$];
    int unsigned  n;
    build_frame(fk, mu, plen, f);
    push_frame(f);
    if (sb.pending && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      for (int unsigned i = 0; i < n; i++) begin
        send_item(OP_PUSH_BYTE, 8'($urandom), i == n - 1);
      end
    end
    drain_reply();
    if ($urandom_range(0, 7) == 0) send_item(OP_PULL_BYTE, 8'd0, 1'b0);
  endtask

  initial begin
    byte unsigned f[$];
    int unsigned  goal;
    logic [31:0]  addrs[4];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_local($urandom);
    send_item(OP_PULL_BYTE, 8'd0, 1'b0);
    run_frame(FK_ICMP, MU_NONE, 5);
    run_frame(FK_TIME, MU_NONE, 4);
    run_frame(FK_ECHO, MU_NONE, 3);
    run_frame(FK_ECHO, MU_OPTIONS, 0);
    run_frame(FK_ICMP, MU_ETHERTYPE, 0);
    run_frame(FK_TIME, MU_TRUNCATE, 0);
    run_frame(FK_ECHO, MU_IHL_LOW, 0);
    run_frame(FK_ECHO, MU_UDP_LEN, 2);
    run_frame(FK_ICMP, MU_OTHER_DST, 1);
    build_frame(FK_TIME, MU_NONE, 0, f);
    push_frame(f);
    send_item(OP_PUSH_BYTE, 8'hFF, 1'b0);
    send_item(OP_PUSH_BYTE, 8'h00, 1'b1);
    drain_reply();

    addrs = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
    foreach (addrs[p]) begin
      set_local(addrs[p]);
      no_idle = (p == 2);
      goal = accepted + 300;
      while (accepted < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2: run_frame(FK_ICMP, MU_NONE, $urandom_range(0, 30));
          3, 4: run_frame(FK_TIME, MU_NONE, $urandom_range(0, 12));
          5, 6: run_frame(FK_ECHO, MU_NONE, $urandom_range(0, 30));
          7, 8: run_frame(frame_kind_e'($urandom_range(0, 2)),
                          mutation_e'($urandom_range(1, MU_COUNT - 1)),
                          $urandom_range(0, 16));
          default: begin
            f.delete();
            repeat ($urandom_range(1, 60)) f.push_back(8'($urandom));
            push_frame(f);
            drain_reply();
          end
        endcase
      end
      if (p == 1) begin
        f.delete();
        repeat (FRAME_DEPTH + 2) f.push_back(8'($urandom));
        push_frame(f);
      end
    end
    no_idle = 0;

    quiesce();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
